// ===== src/tpjs_pkg.sv =====
// Shared types and constants for the three-stage pool job scheduler.
package tpjs_pkg;

	localparam int MAX_UNITS_DEF = 64;
	localparam int TIME_W        = 32;
	localparam int UNITS_W       = 7;
	localparam int SVC_W         = 16;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;
	localparam int OFF_W         = SVC_W + 1;

	typedef logic [TIME_W-1:0] time_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_UNITS_ONE   = 3'd0,
		REG_UNITS_TWO   = 3'd1,
		REG_UNITS_THREE = 3'd2,
		REG_SVC_ONE     = 3'd3,
		REG_SVC_TWO     = 3'd4,
		REG_SVC_THREE   = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		STG_ONE   = 2'd0,
		STG_TWO   = 2'd1,
		STG_THREE = 2'd2
	} stage_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_FOLD,
		ST_WRITE,
		ST_RESULT
	} state_t;

endpackage

// ===== src/tpjs_if.sv =====
// Item channel interfaces of the scheduler.
interface tpjs_in_if;
	logic valid;
	logic ready;
	logic last_job;

	modport source (output valid, output last_job, input ready);
	modport sink (input valid, input last_job, output ready);
endinterface

interface tpjs_out_if;
	logic                 valid;
	logic                 ready;
	tpjs_pkg::time_t      start_time;
	tpjs_pkg::time_t      finish_time;
	tpjs_pkg::time_t      makespan;
	logic                 saturated;
	logic                 batch_done;

	modport source (output valid, output start_time, output finish_time, output makespan,
		output saturated, output batch_done, input ready);
	modport sink (input valid, input start_time, input finish_time, input makespan,
		input saturated, input batch_done, output ready);
endinterface

// ===== src/three_stage_pool_job_scheduler_unit.sv =====
// Top level: greedy three-stage flow-shop scheduler with a shared scan unit.
//
//  channel | dir | handshake           | payload
//  in_ch   | in  | valid/ready         | last_job
//  out_ch  | out | valid/ready         | start_time, finish_time, makespan, saturated, batch_done
//  cfg     | in  | cfg_we              | cfg_index, cfg_data
//
// For each item every stage's pool is read twice through the single read port of
// the free-time memory (min pass, fit pass).
// After reset a clearing pass zeroes all 4*2**clog2(MAX_UNITS) memory entries; no item
// is taken meanwhile. A finished result waits in the output register; the next item
// is accepted meanwhile and holds at its end until that register is free.
module three_stage_pool_job_scheduler_unit #(
	parameter int MAX_UNITS = tpjs_pkg::MAX_UNITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	tpjs_in_if.sink                            in_ch,
	tpjs_out_if.source                         out_ch,
	input  logic                               cfg_we,
	input  logic [tpjs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tpjs_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import tpjs_pkg::*;

	localparam int IW = $clog2(MAX_UNITS);
	localparam int CW = $clog2(MAX_UNITS + 1);
	localparam int AW = IW + 2;
	localparam int DEPTH = 4 * (1 << IW);

	state_t state_q, state_d;

	logic [UNITS_W-1:0] units_q [3];
	logic [SVC_W-1:0]   svc_q [3];

	time_t mem [DEPTH];
	time_t rd_data_s1;
	logic  rd_vld_s1;
	logic [IW-1:0] rd_idx_s1;

	logic [AW-1:0] clr_q;
	stage_t        stage_q;
	logic          fit_q;
	logic [CW-1:0] idx_q;
	logic          found_q;
	time_t         best_q;
	logic [IW-1:0] pick_q;
	logic signed [TIME_W+1:0] st_q;
	logic [OFF_W-1:0] off_q;
	time_t         arrive_q;
	time_t         start_q;
	logic          sat_q;
	logic          last_q;
	time_t         mkspan_q;

	logic          out_valid_q;
	time_t         out_start_q, out_finish_q, out_mk_q;
	logic          out_sat_q, out_done_q;

	logic [CW-1:0]    n_cur;
	logic [SVC_W-1:0] svc_cur;
	logic [UNITS_W-1:0] units_cur;
	logic             issue, scan_done, upd, mem_we, in_ready, out_free, out_load;
	logic [AW-1:0]    wr_addr, rd_addr;
	time_t            wr_data;
	logic signed [TIME_W+1:0] cand, st_nxt;
	logic [TIME_W:0]  sum;
	time_t            done_t;

	// unit count of current stage, clamped to [1, MAX_UNITS]
	always_comb begin
		units_cur = units_q[0];
		svc_cur   = svc_q[0];
		unique case (stage_q)
			STG_ONE: begin
				units_cur = units_q[0];
				svc_cur   = svc_q[0];
			end
			STG_TWO: begin
				units_cur = units_q[1];
				svc_cur   = svc_q[1];
			end
			STG_THREE: begin
				units_cur = units_q[2];
				svc_cur   = svc_q[2];
			end
			default: begin
				units_cur = units_q[0];
				svc_cur   = svc_q[0];
			end
		endcase
		if (units_cur == '0)
			n_cur = CW'(1);
		else if (32'(units_cur) > MAX_UNITS)
			n_cur = CW'(MAX_UNITS);
		else
			n_cur = CW'(units_cur);
	end

	assign issue     = (state_q == ST_SCAN) && (idx_q < n_cur);
	assign scan_done = (state_q == ST_SCAN) && (idx_q == n_cur) && !rd_vld_s1;
	assign rd_addr   = {stage_q, idx_q[IW-1:0]};
	assign out_free  = !out_valid_q || out_ch.ready;
	assign out_load  = (state_q == ST_RESULT) && out_free;

	// shared compare unit
	always_comb begin
		if (fit_q)
			upd = (rd_data_s1 <= arrive_q) && (!found_q || rd_data_s1 > best_q);
		else
			upd = !found_q || (rd_data_s1 < best_q);
	end

	assign cand   = $signed({2'b00, best_q}) - $signed({{(TIME_W+1-OFF_W){1'b0}}, off_q});
	assign st_nxt = (cand > st_q) ? cand : st_q;
	assign sum    = {1'b0, arrive_q} + {{(TIME_W+1-SVC_W){1'b0}}, svc_cur};
	assign done_t = sum[TIME_W] ? '1 : sum[TIME_W-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:  if (clr_q == '1) state_d = ST_IDLE;
			ST_IDLE:   if (in_ch.valid) state_d = ST_SCAN;
			ST_SCAN:   if (scan_done) state_d = fit_q ? ST_WRITE : ST_FOLD;
			ST_FOLD:   state_d = ST_SCAN;
			ST_WRITE:  state_d = (stage_q == STG_THREE) ? ST_RESULT : ST_SCAN;
			ST_RESULT: if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		mem_we   = 1'b0;
		wr_addr  = clr_q;
		wr_data  = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we  = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			ST_IDLE:  in_ready = 1'b1;
			ST_WRITE: begin
				mem_we  = 1'b1;
				wr_addr = {stage_q, pick_q};
				wr_data = done_t;
			end
			default: in_ready = 1'b0;
		endcase
	end

	assign in_ch.ready = in_ready;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (issue)
			rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			units_q <= '{default: UNITS_W'(1)};
			svc_q   <= '{default: SVC_W'(1)};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_UNITS_ONE:   units_q[0] <= cfg_data[UNITS_W-1:0];
				REG_UNITS_TWO:   units_q[1] <= cfg_data[UNITS_W-1:0];
				REG_UNITS_THREE: units_q[2] <= cfg_data[UNITS_W-1:0];
				REG_SVC_ONE:     svc_q[0]   <= cfg_data[SVC_W-1:0];
				REG_SVC_TWO:     svc_q[1]   <= cfg_data[SVC_W-1:0];
				REG_SVC_THREE:   svc_q[2]   <= cfg_data[SVC_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			stage_q     <= STG_ONE;
			fit_q       <= 1'b0;
			idx_q       <= '0;
			found_q     <= 1'b0;
			rd_vld_s1   <= 1'b0;
			mkspan_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: clr_q <= clr_q + AW'(1);
				ST_IDLE: begin
					if (in_ch.valid) begin
						last_q  <= in_ch.last_job;
						stage_q <= STG_ONE;
						fit_q   <= 1'b0;
						idx_q   <= '0;
						found_q <= 1'b0;
						st_q    <= '0;
						off_q   <= '0;
						sat_q   <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (issue)
						idx_q <= idx_q + CW'(1);
					if (rd_vld_s1 && upd) begin
						best_q  <= rd_data_s1;
						pick_q  <= rd_idx_s1;
						found_q <= 1'b1;
					end
				end
				ST_FOLD: begin
					st_q    <= st_nxt;
					off_q   <= off_q + OFF_W'(svc_cur);
					idx_q   <= '0;
					found_q <= 1'b0;
					if (stage_q == STG_THREE) begin
						stage_q  <= STG_ONE;
						fit_q    <= 1'b1;
						arrive_q <= st_nxt[TIME_W-1:0];
						start_q  <= st_nxt[TIME_W-1:0];
					end else begin
						stage_q <= stage_t'(stage_q + 2'd1);
					end
				end
				ST_WRITE: begin
					arrive_q <= done_t;
					sat_q    <= sat_q | sum[TIME_W];
					idx_q    <= '0;
					found_q  <= 1'b0;
					if (stage_q != STG_THREE)
						stage_q <= stage_t'(stage_q + 2'd1);
				end
				ST_RESULT: begin
					if (out_free) begin
						out_start_q  <= start_q;
						out_finish_q <= arrive_q;
						out_mk_q     <= (arrive_q > mkspan_q) ? arrive_q : mkspan_q;
						mkspan_q     <= (arrive_q > mkspan_q) ? arrive_q : mkspan_q;
						out_sat_q    <= sat_q;
						out_done_q   <= last_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (issue)
			rd_idx_s1 <= idx_q[IW-1:0];
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.start_time  = out_start_q;
	assign out_ch.finish_time = out_finish_q;
	assign out_ch.makespan    = out_mk_q;
	assign out_ch.saturated   = out_sat_q;
	assign out_ch.batch_done  = out_done_q;

`ifndef NO_ASSERTIONS
	a_fit_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |-> found_q)
		else $error("fit pass found no free unit");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_FOLD) |-> !mem_we)
		else $error("memory write during scan");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (!out_valid_q && !in_ch.ready))
		else $error("activity during clearing pass");

	a_makespan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_mk_q >= out_finish_q && out_finish_q >= out_start_q))
		else $error("result times out of order");
`endif

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the three-stage pool job scheduler, random flow control.
module testbench;
	import tpjs_pkg::*;

	localparam int NUM_UNITS    = MAX_UNITS_DEF;
	localparam int WATCH_LIMIT  = 20000;
	localparam int HOLD_CYCLES  = 1500;
	localparam int DRAIN_CYCLES = 500;
	localparam int SETTLE_GAP   = 8;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

	typedef struct packed {
		time_t start_time;
		time_t finish_time;
		time_t makespan;
		logic  saturated;
		logic  batch_done;
	} sched_res_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	tpjs_in_if  in_ch();
	tpjs_out_if out_ch();

	three_stage_pool_job_scheduler_unit #(.MAX_UNITS(NUM_UNITS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// scheduler shadow state
	time_t              free_at [3][NUM_UNITS];
	time_t              span_so_far;
	logic [UNITS_W-1:0] unit_cfg [3];
	logic [SVC_W-1:0]   svc_cfg [3];
	sched_res_t         sched_q [$];

	int errors      = 0;
	int hold_cycles = 0;
	int stall_left  = 0;
	int idle_cycles = 0;
	bit idle_on     = 1'b1;

	always #2 clk = ~clk;

	function automatic void clear_schedule();
		for (int s = 0; s < 3; s++) begin
			for (int i = 0; i < NUM_UNITS; i++)
				free_at[s][i] = '0;
			unit_cfg[s] = UNITS_W'(1);
			svc_cfg[s] = SVC_W'(1);
		end
		span_so_far = '0;
	endfunction

	function automatic int pool_size(logic [UNITS_W-1:0] n);
		if (n == 0)
			return 1;
		if (n > NUM_UNITS)
			return NUM_UNITS;
		return int'(n);
	endfunction

	// best-fit unit: largest free time not after arrival; returns {clamped, finish}
	function automatic logic [TIME_W:0] claim_unit(int stg, int n, time_t arrive);
		int pick;
		bit found;
		logic [TIME_W:0] total;
		pick = 0;
		found = 1'b0;
		for (int i = 0; i < n; i++) begin
			if (free_at[stg][i] <= arrive && (!found || free_at[stg][i] > free_at[stg][pick])) begin
				pick = i;
				found = 1'b1;
			end
		end
		total = {1'b0, arrive} + {{(TIME_W + 1 - SVC_W){1'b0}}, svc_cfg[stg]};
		if (total[TIME_W])
			total = {1'b1, {TIME_W{1'b1}}};
		free_at[stg][pick] = total[TIME_W-1:0];
		return total;
	endfunction

	function automatic sched_res_t schedule_job(logic last);
		int n [3];
		longint first_free [3];
		longint st;
		logic [TIME_W:0] step;
		time_t t;
		bit sat;
		sched_res_t r;
		for (int s = 0; s < 3; s++) begin
			n[s] = pool_size(unit_cfg[s]);
			first_free[s] = longint'(free_at[s][0]);
			for (int i = 1; i < n[s]; i++)
				if (longint'(free_at[s][i]) < first_free[s])
					first_free[s] = longint'(free_at[s][i]);
		end
		st = first_free[0];
		if (first_free[1] - longint'(svc_cfg[0]) > st)
			st = first_free[1] - longint'(svc_cfg[0]);
		if (first_free[2] - longint'(svc_cfg[0]) - longint'(svc_cfg[1]) > st)
			st = first_free[2] - longint'(svc_cfg[0]) - longint'(svc_cfg[1]);
		r.start_time = st[TIME_W-1:0];
		t = r.start_time;
		sat = 1'b0;
		for (int s = 0; s < 3; s++) begin
			step = claim_unit(s, n[s], t);
			sat = sat | step[TIME_W];
			t = step[TIME_W-1:0];
		end
		if (t > span_so_far)
			span_so_far = t;
		r.finish_time = t;
		r.makespan = span_so_far;
		r.saturated = sat;
		r.batch_done = last;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 16);
		return $urandom_range(40, 150);
	endfunction

	function automatic logic [UNITS_W-1:0] rand_units();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return UNITS_W'($urandom_range(65, 127));
		if (r < 14)
			return UNITS_W'(0);
		if (r < 22)
			return UNITS_W'(NUM_UNITS);
		if (r < 40)
			return UNITS_W'($urandom_range(9, 63));
		return UNITS_W'($urandom_range(1, 8));
	endfunction

	function automatic logic [SVC_W-1:0] rand_svc();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return SVC_W'(0);
		if (r < 20)
			return {SVC_W{1'b1}};
		if (r < 50)
			return SVC_W'($urandom_range(1, 20));
		return SVC_W'($urandom);
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_UNITS_ONE:   unit_cfg[0] = val[UNITS_W-1:0];
			REG_UNITS_TWO:   unit_cfg[1] = val[UNITS_W-1:0];
			REG_UNITS_THREE: unit_cfg[2] = val[UNITS_W-1:0];
			REG_SVC_ONE:     svc_cfg[0] = val;
			REG_SVC_TWO:     svc_cfg[1] = val;
			REG_SVC_THREE:   svc_cfg[2] = val;
			default: ;
		endcase
	endtask

	task automatic settle();
		while (sched_q.size() != 0 || in_ch.valid)
			@(posedge clk);
		repeat (SETTLE_GAP) @(posedge clk);
	endtask

	// unit counts carry random upper data bits, which the register drops
	task automatic set_stages(logic [UNITS_W-1:0] u1, logic [UNITS_W-1:0] u2,
			logic [UNITS_W-1:0] u3, logic [SVC_W-1:0] s1, logic [SVC_W-1:0] s2,
			logic [SVC_W-1:0] s3);
		settle();
		write_reg(REG_UNITS_ONE, (16'($urandom) & 16'hFF80) | 16'(u1));
		write_reg(REG_UNITS_TWO, (16'($urandom) & 16'hFF80) | 16'(u2));
		write_reg(REG_UNITS_THREE, (16'($urandom) & 16'hFF80) | 16'(u3));
		write_reg(REG_SVC_ONE, s1);
		write_reg(REG_SVC_TWO, s2);
		write_reg(REG_SVC_THREE, s3);
	endtask

	task automatic send_job(logic last);
		int gap;
		gap = idle_on ? pick_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.last_job <= last;
		do
			@(posedge clk);
		while (!in_ch.ready);
		sched_q.insert(sched_q.size(), schedule_job(last));
	endtask

	task automatic quiet_input();
		@(negedge clk);
		in_ch.valid <= 1'b0;
	endtask

	task automatic run_jobs(int count);
		for (int i = 0; i < count; i++)
			send_job($urandom_range(0, 7) == 0);
		quiet_input();
	endtask

	task automatic check_field(string name, time_t want, time_t got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		end
	endtask

	task automatic test_defaults();
		send_job(1'b0);
		send_job(1'b1);
		send_job(1'b0);
		quiet_input();
	endtask

	task automatic test_extremes();
		set_stages(UNITS_W'(NUM_UNITS), UNITS_W'(NUM_UNITS), UNITS_W'(NUM_UNITS),
			16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_jobs(3);
		// zero count acts as one, counts above the pool size act as the pool size
		set_stages(0, 127, 65, 0, 0, 0);
		run_jobs(3);
		set_stages(1, 3, 2, 0, 16'hFFFF, 1);
		run_jobs(2);
		settle();
		write_reg(IDX_SPARE_LO, 16'hFFFF);
		write_reg(IDX_SPARE_HI, 16'h0000);
		send_job(1'b1);
		quiet_input();
	endtask

	task automatic test_unit_resize();
		set_stages(8, 8, 8, 5, 7, 3);
		run_jobs(6);
		// shrunk pools keep the free times of the idle entries
		set_stages(2, 3, 1, 5, 7, 3);
		run_jobs(3);
		set_stages(8, 8, 8, 5, 7, 3);
		run_jobs(3);
	endtask

	task automatic test_random_mix();
		for (int p = 0; p < 10; p++) begin
			set_stages(rand_units(), rand_units(), rand_units(), rand_svc(), rand_svc(),
				rand_svc());
			idle_on = (p % 3) != 2;
			run_jobs(55);
		end
		idle_on = 1'b1;
	endtask

	task automatic test_backpressure();
		set_stages(4, 2, 3, 3, 9, 2);
		idle_on = 1'b0;
		hold_cycles = HOLD_CYCLES;
		run_jobs(12);
		idle_on = 1'b1;
	endtask

	// one unit per stage at the longest service: times grow by a full service per item
	task automatic test_long_service();
		set_stages(1, 1, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		idle_on = 1'b0;
		run_jobs(20);
		idle_on = 1'b1;
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			out_ch.ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			stall_left = hold_cycles - 1;
			hold_cycles = 0;
			out_ch.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 99) < 30) begin
			stall_left = pick_gap();
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		sched_res_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (sched_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected item start=%0d finish=%0d", $time,
					out_ch.start_time, out_ch.finish_time);
			end else begin
				want = sched_q.pop_front();
				check_field("start_time", want.start_time, out_ch.start_time);
				check_field("finish_time", want.finish_time, out_ch.finish_time);
				check_field("makespan", want.makespan, out_ch.makespan);
				check_field("saturated", time_t'(want.saturated), time_t'(out_ch.saturated));
				check_field("batch_done", time_t'(want.batch_done), time_t'(out_ch.batch_done));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles = idle_cycles + 1;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.last_job = 1'b0;
		out_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		clear_schedule();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_defaults();
		test_extremes();
		test_unit_resize();
		test_random_mix();
		test_backpressure();
		test_long_service();
		while (sched_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
